### rtl/bmprle_pkg.sv
// Shared types and constants for the bitmap RLE8/RLE4 decoder.
// No dependencies; used by bmprle_core and bmp_rle_decoder_unit.
package bmprle_pkg;

  // Decode phase of the byte stream
  typedef enum logic [2:0] {
    PH_COUNT,
    PH_VALUE,
    PH_DX,
    PH_DY,
    PH_ABS,
    PH_PAD
  } phase_t;

  // Configuration register indexes
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam logic [CFG_IDX_W-1:0] CFG_FOUR_BIT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_DOWN = 3'd3;

  // Escape codes that follow a zero-length run
  localparam logic [7:0] ESC_EOL   = 8'd0;
  localparam logic [7:0] ESC_EOP   = 8'd1;
  localparam logic [7:0] ESC_DELTA = 8'd2;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       image_start;
  } in_item_t;

  typedef struct packed {
    logic        write_valid;
    logic [11:0] row;
    logic [11:0] start_column;
    logic [7:0]  run_length;
    logic [7:0]  even_index;
    logic [7:0]  odd_index;
    logic        picture_done;
  } out_item_t;

  typedef struct packed {
    logic        four_bit_mode;
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic        top_down;
  } cfg_t;

endpackage

### rtl/bmp_rle_decoder_unit.sv
// Bitmap RLE8/RLE4 decoder: one compressed byte in, one result item out per byte.
// The result is registered at the accepting edge, into the output or skid register.
// Throughput: one byte per cycle; decode is a single combinational pass into the
// output register, backed by a skid register; input stalls only while both hold an item.
// Reset (synchronous, rst_n low): decode restarts at the first row, column zero,
// configuration returns to RLE8, width 1, height 1, bottom-up; output is empty.
module bmp_rle_decoder_unit #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  bmprle_pkg::in_item_t                in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output bmprle_pkg::out_item_t               out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bmprle_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bmprle_pkg::CFG_DATA_W-1:0]   cfg_data
);

  // Configuration registers
  bmprle_pkg::cfg_t cfg_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.four_bit_mode <= 1'b0;
      cfg_r.image_width   <= 13'd1;
      cfg_r.image_height  <= 13'd1;
      cfg_r.top_down      <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bmprle_pkg::CFG_FOUR_BIT: cfg_r.four_bit_mode <= cfg_data[0];
        bmprle_pkg::CFG_WIDTH:    cfg_r.image_width   <= cfg_data;
        bmprle_pkg::CFG_HEIGHT:   cfg_r.image_height  <= cfg_data;
        bmprle_pkg::CFG_TOP_DOWN: cfg_r.top_down      <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Decoder
  logic                  in_fire, out_fire, slot_free;
  bmprle_pkg::out_item_t res;

  bmprle_core #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (in_fire),
    .item  (in_data),
    .cfg   (cfg_r),
    .res   (res)
  );

  // Output register plus skid register
  logic                  out_valid_r, skid_valid_r;
  bmprle_pkg::out_item_t out_data_r, skid_data_r;

  assign in_stall  = skid_valid_r;
  assign in_fire   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_fire  = out_valid_r && !out_stall;
  assign slot_free = out_fire || !out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (slot_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
      end else if (in_fire) begin
        out_data_r <= res;
      end
    end else if (in_fire) begin
      skid_data_r <= res;
    end
  end

`ifndef SYNTH
  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r && !skid_valid_r)
    else $error("output stages not empty after reset");

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds an item while output register is empty");

  a_skid_fill_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && out_stall && in_fire))
    else $error("skid filled without a stalled output");

  a_write_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.write_valid |-> out_data_r.run_length != 8'd0)
    else $error("run write with zero length");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.write_valid |-> out_data_r.run_length == 8'd0)
    else $error("dropped write carries a length");
`endif

endmodule

### rtl/bmprle_core.sv
// Decode state and single-pass byte decode logic for the RLE8/RLE4 decoder.
// Depends on bmprle_pkg. Result is combinational; state advances on each item.
module bmprle_core #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  fire,
  input  bmprle_pkg::in_item_t  item,
  input  bmprle_pkg::cfg_t      cfg,
  output bmprle_pkg::out_item_t res
);

  localparam logic [15:0] MAX_W16 = 16'(MAX_WIDTH);
  localparam logic [15:0] MAX_H16 = 16'(MAX_HEIGHT);

  function automatic logic [15:0] sat16(input logic [16:0] v);
    sat16 = v[16] ? 16'hFFFF : v[15:0];
  endfunction

  // State registers
  bmprle_pkg::phase_t phase_r, phase_nxt;
  logic [15:0] col_r, col_nxt;
  logic [15:0] row_r, row_nxt;
  logic [7:0]  held_r, held_nxt;
  logic [7:0]  total_r, total_nxt;
  logic [7:0]  seen_r, seen_nxt;
  logic        done_r, done_nxt;

  // State as seen by this item, after an optional restart
  bmprle_pkg::phase_t s_phase;
  logic [15:0] s_col, s_row;
  logic [7:0]  s_held, s_total, s_seen;
  logic        s_done;

  logic [7:0]  b;
  logic [3:0]  hi, lo;
  logic [15:0] w, h;

  assign b  = item.stream_byte;
  assign hi = b[7:4];
  assign lo = b[3:0];

  assign s_phase = item.image_start ? bmprle_pkg::PH_COUNT : phase_r;
  assign s_col   = item.image_start ? 16'd0 : col_r;
  assign s_row   = item.image_start ? 16'd0 : row_r;
  assign s_held  = item.image_start ? 8'd0  : held_r;
  assign s_total = item.image_start ? 8'd0  : total_r;
  assign s_seen  = item.image_start ? 8'd0  : seen_r;
  assign s_done  = item.image_start ? 1'b0  : done_r;

  // Effective image size, clamped to 1..MAX
  always_comb begin
    if (cfg.image_width == 13'd0) begin
      w = 16'd1;
    end else if ({3'd0, cfg.image_width} > MAX_W16) begin
      w = MAX_W16;
    end else begin
      w = {3'd0, cfg.image_width};
    end
    if (cfg.image_height == 13'd0) begin
      h = 16'd1;
    end else if ({3'd0, cfg.image_height} > MAX_H16) begin
      h = MAX_H16;
    end else begin
      h = {3'd0, cfg.image_height};
    end
  end

  // Encoded run: count clipped to the width
  logic [16:0] col_plus_held;
  logic [15:0] w_minus_col;
  logic        col_lt_w, run_clip, cnt_pos;
  logic [7:0]  cnt8;

  assign col_plus_held = {1'b0, s_col} + 17'(s_held);
  assign w_minus_col   = w - s_col;
  assign col_lt_w      = s_col < w;
  assign run_clip      = col_plus_held > {1'b0, w};
  assign cnt_pos       = run_clip ? col_lt_w : (s_held != 8'd0);
  assign cnt8          = run_clip ? w_minus_col[7:0] : s_held;

  // Absolute run: pixels covered by this byte and bytes needed
  logic [8:0] first_px, left_px, need4;
  logic [7:0] need, seen_inc;
  logic [1:0] abs_n;

  assign first_px = {s_seen, 1'b0};
  assign left_px  = ({1'b0, s_total} > first_px) ? ({1'b0, s_total} - first_px) : 9'd0;
  assign need4    = ({1'b0, s_total} + 9'd1) >> 1;
  assign need     = cfg.four_bit_mode ? need4[7:0] : s_total;
  assign seen_inc = (s_seen < 8'hFF) ? (s_seen + 8'd1) : s_seen;

  always_comb begin
    if (cfg.four_bit_mode) begin
      abs_n = (left_px < 9'd2) ? left_px[1:0] : 2'd2;
    end else begin
      abs_n = {1'b0, s_seen < s_total};
    end
  end

  // Next-state logic
  logic [15:0] col_a, row_a, row_nl;
  logic        do_finish, force_nl, done_a, new_line;

  always_comb begin
    phase_nxt = s_phase;
    held_nxt  = s_held;
    total_nxt = s_total;
    seen_nxt  = s_seen;
    col_a     = s_col;
    row_a     = s_row;
    done_a    = s_done;
    do_finish = 1'b0;
    force_nl  = 1'b0;
    if (!s_done) begin
      case (s_phase)
        bmprle_pkg::PH_COUNT: begin
          held_nxt  = b;
          phase_nxt = bmprle_pkg::PH_VALUE;
        end
        bmprle_pkg::PH_VALUE: begin
          if (cnt_pos) begin
            col_a     = s_col + 16'(cnt8);
            do_finish = 1'b1;
          end else if (b == bmprle_pkg::ESC_EOL) begin
            force_nl  = 1'b1;
            phase_nxt = bmprle_pkg::PH_COUNT;
          end else if (b == bmprle_pkg::ESC_EOP) begin
            done_a    = 1'b1;
            phase_nxt = bmprle_pkg::PH_COUNT;
          end else if (b == bmprle_pkg::ESC_DELTA) begin
            phase_nxt = bmprle_pkg::PH_DX;
          end else begin
            total_nxt = b;
            seen_nxt  = 8'd0;
            phase_nxt = bmprle_pkg::PH_ABS;
          end
        end
        bmprle_pkg::PH_DX: begin
          held_nxt  = b;
          phase_nxt = bmprle_pkg::PH_DY;
        end
        bmprle_pkg::PH_DY: begin
          col_a     = sat16(col_plus_held);
          row_a     = sat16({1'b0, s_row} + 17'(b));
          do_finish = 1'b1;
        end
        bmprle_pkg::PH_ABS: begin
          col_a    = sat16({1'b0, s_col} + 17'(abs_n));
          seen_nxt = seen_inc;
          if (seen_inc >= need) begin
            if (need[0]) begin
              phase_nxt = bmprle_pkg::PH_PAD;
            end else begin
              do_finish = 1'b1;
            end
          end
        end
        bmprle_pkg::PH_PAD: begin
          do_finish = 1'b1;
        end
        default: begin
          phase_nxt = bmprle_pkg::PH_COUNT;
        end
      endcase
    end
    if (do_finish) begin
      phase_nxt = bmprle_pkg::PH_COUNT;
    end
  end

  // Line end: explicit, or an overlong line after a finished command
  assign new_line = force_nl || (do_finish && ({1'b0, col_a} > ({1'b0, w} + 17'd1)));
  assign row_nl   = sat16({1'b0, row_a} + 17'd1);
  assign col_nxt  = new_line ? 16'd0 : col_a;
  assign row_nxt  = new_line ? row_nl : row_a;
  assign done_nxt = done_a || (new_line && (row_nl >= h));

  // Run write selection
  logic       em_en;
  logic [7:0] em_len, em_ev, em_od;

  always_comb begin
    em_en  = 1'b0;
    em_len = 8'd0;
    em_ev  = b;
    em_od  = b;
    if (cfg.four_bit_mode) begin
      em_ev = {4'd0, hi};
      em_od = {4'd0, lo};
    end
    if (!s_done) begin
      case (s_phase)
        bmprle_pkg::PH_VALUE: begin
          em_en  = cnt_pos;
          em_len = cnt8;
        end
        bmprle_pkg::PH_ABS: begin
          em_en  = 1'b1;
          em_len = 8'(abs_n);
        end
        default: begin
          em_en = 1'b0;
        end
      endcase
    end
  end

  // Clip the write to the image
  logic [16:0] em_end;
  logic [7:0]  wr_len;
  logic [15:0] wr_row;
  logic        wr_ok;

  assign em_end = {1'b0, s_col} + 17'(em_len);
  assign wr_len = (em_end > {1'b0, w}) ? w_minus_col[7:0] : em_len;
  assign wr_row = cfg.top_down ? s_row : (h - 16'd1 - s_row);
  assign wr_ok  = em_en && (em_len != 8'd0) && (s_row < h) && col_lt_w;

  always_comb begin
    res              = '0;
    res.write_valid  = wr_ok;
    res.picture_done = done_nxt;
    if (wr_ok) begin
      res.row          = wr_row[11:0];
      res.start_column = s_col[11:0];
      res.run_length   = wr_len;
      res.even_index   = em_ev;
      res.odd_index    = em_od;
    end
  end

  // State update on each accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= bmprle_pkg::PH_COUNT;
      col_r   <= '0;
      row_r   <= '0;
      held_r  <= '0;
      total_r <= '0;
      seen_r  <= '0;
      done_r  <= 1'b0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      held_r  <= held_nxt;
      total_r <= total_nxt;
      seen_r  <= seen_nxt;
      done_r  <= done_nxt;
    end
  end

endmodule

### tb/tb_bmp_rle_decoder_unit.sv
// Self-checking testbench for bmp_rle_decoder_unit: RLE8/RLE4 byte streams in,
// pixel-run writes out, checked against a cycle-free predictor kept in a class.
// Depends on rtl/bmprle_pkg.sv, rtl/bmp_rle_decoder_unit.sv and rtl/bmprle_core.sv.
`timescale 1ns / 100ps

module tb_bmp_rle_decoder_unit;
  import bmprle_pkg::*;

  localparam int MAX_W           = 4096;
  localparam int MAX_H           = 4096;
  localparam int HOLD_CYCLES     = 300;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 190;

  // Predicts the run write of every accepted byte and checks the results in order
  class pixel_run_tracker;
    bit     four_bit;
    int     width_reg;
    int     height_reg;
    bit     top_down;
    phase_t phase;
    int     column;
    int     cur_row;
    int     held_count;
    int     abs_total;
    int     abs_seen;
    bit     done_flag;
    out_item_t expected_runs[$];
    out_item_t cur;
    int     errors;

    function new();
      errors = 0;
      four_bit = 0;
      width_reg = 1;
      height_reg = 1;
      top_down = 0;
      restart();
    endfunction

    function void restart();
      phase = PH_COUNT;
      column = 0;
      cur_row = 0;
      held_count = 0;
      abs_total = 0;
      abs_seen = 0;
      done_flag = 0;
    endfunction

    function int eff_w();
      if (width_reg < 1) return 1;
      if (width_reg > MAX_W) return MAX_W;
      return width_reg;
    endfunction

    function int eff_h();
      if (height_reg < 1) return 1;
      if (height_reg > MAX_H) return MAX_H;
      return height_reg;
    endfunction

    function int sat16(int v);
      return (v > 65535) ? 65535 : v;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_FOUR_BIT: four_bit = data[0];
        CFG_WIDTH:    width_reg = data;
        CFG_HEIGHT:   height_reg = data;
        CFG_TOP_DOWN: top_down = data[0];
        default: ;
      endcase
    endfunction

    // Run write, dropped outside the image and shortened at the right edge
    function void emit(int col, int len, int ev, int od);
      int w;
      int h;
      int r;
      w = eff_w();
      h = eff_h();
      if (len == 0 || cur_row >= h || col >= w) return;
      if (col + len > w) len = w - col;
      r = top_down ? cur_row : (h - 1 - cur_row);
      cur.write_valid  = 1'b1;
      cur.row          = 12'(r);
      cur.start_column = 12'(col);
      cur.run_length   = 8'(len);
      cur.even_index   = 8'(ev);
      cur.odd_index    = 8'(od);
    endfunction

    function void new_line();
      column = 0;
      cur_row = sat16(cur_row + 1);
      if (cur_row >= eff_h()) done_flag = 1;
    endfunction

    // After a complete command an overlong line wraps
    function void finish_cmd();
      phase = PH_COUNT;
      if (column > eff_w() + 1) new_line();
    endfunction

    function void note_byte(in_item_t it);
      int b;
      int hi;
      int lo;
      int cnt;
      int need;
      int n;
      int first;
      int left;
      cur = '0;
      b = it.stream_byte;
      hi = b >> 4;
      lo = b & 15;
      if (it.image_start) restart();
      if (!done_flag) begin
        case (phase)
          PH_COUNT: begin
            held_count = b;
            phase = PH_VALUE;
          end
          PH_VALUE: begin
            cnt = held_count;
            if (column + held_count > eff_w()) cnt = eff_w() - column;
            if (cnt > 0) begin
              if (four_bit) emit(column, cnt, hi, lo);
              else emit(column, cnt, b, b);
              column = sat16(column + cnt);
              finish_cmd();
            end else if (b == ESC_EOL) begin
              new_line();
              phase = PH_COUNT;
            end else if (b == ESC_EOP) begin
              done_flag = 1;
              phase = PH_COUNT;
            end else if (b == ESC_DELTA) begin
              phase = PH_DX;
            end else begin
              abs_total = b;
              abs_seen = 0;
              phase = PH_ABS;
            end
          end
          PH_DX: begin
            held_count = b;
            phase = PH_DY;
          end
          PH_DY: begin
            column = sat16(column + held_count);
            cur_row = sat16(cur_row + b);
            finish_cmd();
          end
          PH_ABS: begin
            if (four_bit) begin
              first = abs_seen * 2;
              left = (abs_total > first) ? abs_total - first : 0;
              need = (abs_total + 1) >> 1;
              n = (left < 2) ? left : 2;
              emit(column, n, hi, lo);
            end else begin
              need = abs_total;
              n = (abs_seen < abs_total) ? 1 : 0;
              emit(column, n, b, b);
            end
            column = sat16(column + n);
            if (abs_seen < 255) abs_seen++;
            if (abs_seen >= need) begin
              if (need & 1) phase = PH_PAD;
              else finish_cmd();
            end
          end
          PH_PAD: finish_cmd();
          default: phase = PH_COUNT;
        endcase
      end
      cur.picture_done = done_flag;
      expected_runs.push_back(cur);
    endfunction

    function void field_diff(string name, int e, int a);
      if (e != a) begin
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, e, a);
        errors++;
      end
    endfunction

    function void check_write(out_item_t act);
      out_item_t exp_run;
      if (expected_runs.size() == 0) begin
        $display("%0t: result with nothing expected, expected none actual %h", $time, act);
        errors++;
        return;
      end
      exp_run = expected_runs.pop_front();
      field_diff("write_valid",  exp_run.write_valid,  act.write_valid);
      field_diff("row",          exp_run.row,          act.row);
      field_diff("start_column", exp_run.start_column, act.start_column);
      field_diff("run_length",   exp_run.run_length,   act.run_length);
      field_diff("even_index",   exp_run.even_index,   act.even_index);
      field_diff("odd_index",    exp_run.odd_index,    act.odd_index);
      field_diff("picture_done", exp_run.picture_done, act.picture_done);
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  in_item_t   in_data;
  logic       out_valid;
  logic       out_stall;
  out_item_t  out_data;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pixel_run_tracker tracker;
  bit long_hold_req;
  int burst_left;
  int cycle_count;

  bmp_rle_decoder_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Clock
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Watchdog
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_bmp_rle_decoder_unit failed");
      $finish;
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) tracker.check_write(out_data);
  end

  // Receiver: stall patterns that change now and then, plus one long hold-off on request
  initial begin
    int mode;
    int span;
    out_stall = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 150);
      repeat (span) begin
        @(negedge clk);
        if (long_hold_req) begin
          out_stall = 1'b1;
          repeat (HOLD_CYCLES) @(negedge clk);
          long_hold_req = 1'b0;
        end else begin
          case (mode)
            0: out_stall = 1'b0;
            1: out_stall = $urandom_range(0, 1);
            2: out_stall = ~out_stall;
            default: out_stall = ($urandom_range(0, 9) < 8);
          endcase
        end
      end
    end
  end

  // One item on the input channel, in bursts with random gaps
  task automatic drive_byte(input logic [7:0] b, input logic start);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid = 1'b1;
    in_data.stream_byte = b;
    in_data.image_start = start;
    do @(posedge clk); while (in_stall);
    tracker.note_byte(in_data);
  endtask

  // Stop sending and wait until every expected write has come back
  task automatic drain_outputs();
    @(negedge clk);
    in_valid = 1'b0;
    while (tracker.expected_runs.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = CFG_DATA_W'(data);
    do @(posedge clk); while (!cfg_ready);
    tracker.set_reg(idx, CFG_DATA_W'(data));
  endtask

  task automatic set_config(input int four, input int w, input int h, input int top);
    cfg_write(CFG_FOUR_BIT, four);
    cfg_write(CFG_WIDTH, w);
    cfg_write(CFG_HEIGHT, h);
    cfg_write(CFG_TOP_DOWN, top);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_seq(input logic [7:0] seq[$], input logic start);
    foreach (seq[i]) drive_byte(seq[i], (i == 0) ? start : 1'b0);
  endtask

  // Mostly well-formed commands with random content, some noise and cut-off runs
  task automatic send_command(inout int sent);
    logic [7:0] q[$];
    int kind;
    int n;
    int nbytes;
    int w;
    logic start;
    w = tracker.eff_w();
    start = tracker.done_flag || ($urandom_range(0, 99) < 3);
    kind = $urandom_range(0, 99);
    if (kind < 40) begin
      if ($urandom_range(0, 3) == 0) n = $urandom_range(0, 255);
      else n = $urandom_range(1, (w < 24) ? w : 24);
      q.push_back(8'(n));
      q.push_back(8'($urandom_range(0, 255)));
    end else if (kind < 55) begin
      q.push_back(8'h00);
      q.push_back(ESC_EOL);
    end else if (kind < 65) begin
      q.push_back(8'h00);
      q.push_back(ESC_DELTA);
      q.push_back(8'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                  : $urandom_range(0, 6)));
      q.push_back(8'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                  : $urandom_range(0, 2)));
    end else if (kind < 90) begin
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(3, 255) : $urandom_range(3, 30);
      q.push_back(8'h00);
      q.push_back(8'(n));
      nbytes = tracker.four_bit ? (n + 1) / 2 : n;
      repeat (nbytes) q.push_back(8'($urandom_range(0, 255)));
      if (nbytes & 1) q.push_back(8'($urandom_range(0, 255)));
      // cut-off absolute run
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, q.size() - 1)) void'(q.pop_back());
    end else if (kind < 93) begin
      q.push_back(8'h00);
      q.push_back(ESC_EOP);
    end else begin
      repeat ($urandom_range(1, 3)) q.push_back(8'($urandom_range(0, 255)));
    end
    foreach (q[i]) drive_byte(q[i], (i == 0) ? start : ($urandom_range(0, 99) == 0));
    sent += q.size();
  endtask

  // Main sequence
  initial begin
    logic [7:0] dir[$];
    int sent;
    int four;
    int w;
    int h;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    long_hold_req = 1'b0;
    burst_left = 0;
    tracker = new();
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // Directed, RLE8 bottom-up: plain run, run clipped at the edge, a clip to zero
    // read as end of line, overlong displacement, odd absolute run with pad,
    // end of line on the last row, ending the picture, then bytes ignored while done
    set_config(0, 6, 3, 0);
    dir = {8'd3, 8'h55, 8'd10, 8'hAA, 8'd4, 8'h00,
           8'h00, ESC_DELTA, 8'hFF, 8'h00,
           8'h00, 8'd3, 8'h11, 8'h22, 8'h33, 8'h00,
           8'h00, ESC_EOL, 8'hFF, 8'h07, 8'h00, ESC_EOP, 8'h12};
    send_seq(dir, 1'b1);
    drain_outputs();

    // Directed, RLE4 top-down at full size, then a mode change inside an absolute run
    set_config(1, MAX_W, MAX_H, 1);
    dir = {8'd8, 8'hAB, 8'h00, 8'd5, 8'h12, 8'h34, 8'h56, 8'h00, 8'h00, 8'd6, 8'h9A};
    send_seq(dir, 1'b1);
    drain_outputs();
    cfg_write(CFG_FOUR_BIT, 0);
    @(negedge clk);
    cfg_valid = 1'b0;
    dir = {8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66};
    send_seq(dir, 1'b0);
    drain_outputs();

    // Random phases, each with its own settings
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: set_config(0, 1, 1, 0);
        1: set_config(1, MAX_W, MAX_H, 1);
        2: set_config(0, MAX_W, MAX_H, 0);
        3: set_config(1, 1, 1, 1);
        default: begin
          four = $urandom_range(0, 1);
          w = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 40) : $urandom_range(1, MAX_W);
          h = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 8) : $urandom_range(1, MAX_H);
          set_config(four, w, h, $urandom_range(0, 1));
        end
      endcase
      // long receiver hold-off while the sender keeps offering items
      if (p == 4) long_hold_req = 1'b1;
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        send_command(sent);
        // sender pause until everything is back
        if (p == 5 && sent >= ITEMS_PER_PHASE / 2 && sent < ITEMS_PER_PHASE / 2 + 6)
          drain_outputs();
      end
      drain_outputs();
    end

    repeat (10) @(negedge clk);
    if (tracker.errors == 0 && tracker.expected_runs.size() == 0) begin
      $display("tb_bmp_rle_decoder_unit passed");
    end else begin
      $display("tb_bmp_rle_decoder_unit failed");
    end
    $finish;
  end

endmodule
